/* sv/sorted_word_prefix_lookup_top_defines.svh */
// Assertion macros used by the checker file.
`ifndef SORTED_WORD_PREFIX_LOOKUP_TOP_DEFINES_SVH
`define SORTED_WORD_PREFIX_LOOKUP_TOP_DEFINES_SVH

// Implication checked every cycle outside reset.
`define SWPL_ASSERT_IMPL(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Implication checked on the next cycle outside reset.
`define SWPL_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

// Property checked on the cycle after reset is seen.
`define SWPL_ASSERT_RESET(label, prop, msg) \
   label: assert property (@(posedge clock) reset |=> (prop)) else $error(msg);

`endif

/* sv/swpl_pkg.sv */
// Shared types and codes of the sorted word prefix lookup.
package swpl_pkg;

   localparam int LEN_BITS   = 6;
   localparam int WORD_BITS  = 20;
   localparam int COUNT_BITS = 21;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_CLEAR = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      ST_FOUND    = 2'd0,
      ST_PREFIX   = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_TOOLONG  = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] character;
      logic       last;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] match_index;
   } rsp_word_type;

   typedef struct packed {
      logic                 byte_we;
      logic                 len_we;
      logic                 tgt_we;
      logic [WORD_BITS-1:0] word;
      logic [LEN_BITS-1:0]  pos;
      logic [LEN_BITS-1:0]  len;
      logic [7:0]           data;
   } wr_type;

   typedef struct packed {
      logic                  ovf;
      logic [LEN_BITS-1:0]   qlen;
      logic [COUNT_BITS-1:0] count;
   } job_type;

endpackage

/* sv/sorted_word_prefix_lookup_top.sv */
// Top level of the sorted word prefix lookup.
//
// Request channel: drive req_word with start high; the word is taken at a clock
// edge where busy is low. Commands: load a table byte, send a query byte, or
// clear the table. Table words must arrive in ascending bytewise order.
// Load, clear and non-final query bytes do not raise busy.
// The final byte of a query posts a search job; busy stays high until the
// answer has been produced. Each probe of the binary search reads the entry's
// length, then compares bytes one at a time up to the shorter of the two
// lengths, stopping at the first byte that differs; a search takes up to
// ceil(log2(word_count+1)) + 1 probes, each using the single table memory read
// port. An overlong query is answered from the idle state without a search.
// Response channel: rsp_valid strobes for one cycle with rsp_word; the
// receiver cannot stall, so every result must be taken on that cycle.
// Reset clears counters, positions, the job queue, the search state and the
// strobe. Table contents are not cleared; only written entries are ever used.
module sorted_word_prefix_lookup_top import swpl_pkg::*; #(
   parameter int MAX_WORDS = 4096,
   parameter int MAX_LEN   = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);
   wr_type  wr;
   job_type push_job, head_job;
   logic    accept, push, pop, job_valid, active;

   // Hold off new words while any search is queued or running.
   assign busy   = job_valid | active;
   assign accept = start & ~busy;

   swpl_front #(.MAX_WORDS(MAX_WORDS), .MAX_LEN(MAX_LEN)) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_word (req_word),
      .wr       (wr),
      .push     (push),
      .job      (push_job)
   );

   swpl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .valid    (job_valid),
      .head     (head_job)
   );

   swpl_back #(.MAX_WORDS(MAX_WORDS), .MAX_LEN(MAX_LEN)) u_back (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .job_valid (job_valid),
      .job       (head_job),
      .pop       (pop),
      .active    (active),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );
endmodule

/* sv/swpl_front.sv */
// Front end: takes words, tracks load and query positions, issues search jobs.
module swpl_front import swpl_pkg::*; #(
   parameter int MAX_WORDS = 4096,
   parameter int MAX_LEN   = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_word_type req_word,
   output wr_type       wr,
   output logic         push,
   output job_type      job
);
   localparam int CW = $clog2(MAX_WORDS + 1);
   localparam int LW = $clog2(MAX_LEN + 1);

   logic [CW-1:0] count_ff, count_in;
   logic [LW-1:0] lpos_ff, lpos_in, tpos_ff, tpos_in;
   logic          lovf_ff, lovf_in, tovf_ff, tovf_in;

   always_comb begin
      count_in = count_ff;
      lpos_in  = lpos_ff;
      lovf_in  = lovf_ff;
      tpos_in  = tpos_ff;
      tovf_in  = tovf_ff;
      wr       = '0;
      push     = 1'b0;
      job      = '0;
      if (accept) begin
         case (req_word.command)
            CMD_LOAD: begin
               if (count_ff >= CW'(MAX_WORDS) || lpos_ff >= LW'(MAX_LEN)) begin
                  lovf_in = 1'b1;
               end else begin
                  wr.byte_we = 1'b1;
                  wr.word    = WORD_BITS'(count_ff);
                  wr.pos     = LEN_BITS'(lpos_ff);
                  wr.data    = req_word.character;
                  lpos_in    = lpos_ff + 1'b1;
               end
               if (req_word.last) begin
                  if (!lovf_in && lpos_in != '0 && count_ff < CW'(MAX_WORDS)) begin
                     wr.len_we = 1'b1;
                     wr.word   = WORD_BITS'(count_ff);
                     wr.len    = LEN_BITS'(lpos_in);
                     count_in  = count_ff + 1'b1;
                  end
                  lpos_in = '0;
                  lovf_in = 1'b0;
               end
            end
            CMD_QUERY: begin
               if (tpos_ff >= LW'(MAX_LEN)) begin
                  tovf_in = 1'b1;
               end else begin
                  wr.tgt_we = 1'b1;
                  wr.pos    = LEN_BITS'(tpos_ff);
                  wr.data   = req_word.character;
                  tpos_in   = tpos_ff + 1'b1;
               end
               if (req_word.last) begin
                  push      = 1'b1;
                  job.ovf   = tovf_in;
                  job.qlen  = LEN_BITS'(tpos_in);
                  job.count = COUNT_BITS'(count_ff);
                  tpos_in   = '0;
                  tovf_in   = 1'b0;
               end
            end
            CMD_CLEAR: begin
               count_in = '0;
               lpos_in  = '0;
               lovf_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         lpos_ff  <= '0;
         lovf_ff  <= 1'b0;
         tpos_ff  <= '0;
         tovf_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         lpos_ff  <= lpos_in;
         lovf_ff  <= lovf_in;
         tpos_ff  <= tpos_in;
         tovf_ff  <= tovf_in;
      end
   end
endmodule

/* sv/swpl_queue.sv */
// Two-entry job queue between front and back.
module swpl_queue import swpl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    valid,
   output job_type head
);
   job_type    slot_ff [2];
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] fill_ff, fill_in;

   always_comb begin
      rd_in   = rd_ff;
      wr_in   = wr_ff;
      fill_in = fill_ff;
      if (push) begin
         wr_in = ~wr_ff;
      end
      if (pop) begin
         rd_in = ~rd_ff;
      end
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   assign valid = fill_ff != 2'd0;
   assign head  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
      if (reset) begin
         rd_ff   <= 1'b0;
         wr_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         rd_ff   <= rd_in;
         wr_ff   <= wr_in;
         fill_ff <= fill_in;
      end
   end
endmodule

/* sv/swpl_back.sv */
// Back end: table memories and the byte-serial binary search.
module swpl_back import swpl_pkg::*; #(
   parameter int MAX_WORDS = 4096,
   parameter int MAX_LEN   = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  wr_type       wr,
   input  logic         job_valid,
   input  job_type      job,
   output logic         pop,
   output logic         active,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);
   localparam int CW = $clog2(MAX_WORDS + 1);
   localparam int IW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int TW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int AW = (MAX_WORDS * MAX_LEN > 1) ? $clog2(MAX_WORDS * MAX_LEN) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_STEP, S_LEN, S_LENW, S_RD, S_CHK, S_RESOLVE
   } state_type;

   typedef enum logic [1:0] { C_LT, C_EQ, C_GT } cmp_type;

   logic [7:0]          bytes_mem   [MAX_WORDS * MAX_LEN];
   logic [LEN_BITS-1:0] lengths_mem [MAX_WORDS];
   logic [7:0]          target_mem  [MAX_LEN];

   state_type     state_ff, state_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, count_ff, count_in;
   logic [LW-1:0] qlen_ff, qlen_in, elen_ff, elen_in, i_ff, i_in;
   logic [IW-1:0] entry_ff, entry_in;
   logic          final_ff, final_in, mism_ff, mism_in;
   cmp_type       cmp_ff, cmp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_ff, rsp_in;

   logic [LEN_BITS-1:0] len_rd_ff;
   logic [7:0]          byte_rd_ff, tgt_rd_ff;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [CW-1:0]       mid;
   logic [LW-1:0]       n;

   assign wr_addr = AW'(wr.word[IW-1:0]) * AW'(MAX_LEN) + AW'(wr.pos);
   assign rd_addr = AW'(entry_ff) * AW'(MAX_LEN) + AW'(i_ff);
   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign n       = (elen_ff < qlen_ff) ? elen_ff : qlen_ff;

   always_ff @(posedge clock) begin
      if (wr.byte_we) begin
         bytes_mem[wr_addr] <= wr.data;
      end
      if (wr.len_we) begin
         lengths_mem[wr.word[IW-1:0]] <= wr.len;
      end
      if (wr.tgt_we) begin
         target_mem[wr.pos[TW-1:0]] <= wr.data;
      end
      len_rd_ff  <= lengths_mem[entry_ff];
      byte_rd_ff <= bytes_mem[rd_addr];
      tgt_rd_ff  <= target_mem[i_ff[TW-1:0]];
   end

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      count_in     = count_ff;
      qlen_in      = qlen_ff;
      elen_in      = elen_ff;
      i_in         = i_ff;
      entry_in     = entry_ff;
      final_in     = final_ff;
      mism_in      = mism_ff;
      cmp_in       = cmp_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               pop      = 1'b1;
               qlen_in  = LW'(job.qlen);
               count_in = CW'(job.count);
               lo_in    = '0;
               hi_in    = CW'(job.count);
               if (job.ovf) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: ST_TOOLONG, match_index: '0};
               end else begin
                  state_in = S_STEP;
               end
            end
         end
         S_STEP: begin
            if (lo_ff < hi_ff) begin
               entry_in = mid[IW-1:0];
               final_in = 1'b0;
               state_in = S_LEN;
            end else if (lo_ff < count_ff) begin
               entry_in = lo_ff[IW-1:0];
               final_in = 1'b1;
               state_in = S_LEN;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_NOTFOUND, match_index: '0};
               state_in     = S_IDLE;
            end
         end
         S_LEN: begin
            state_in = S_LENW;
         end
         S_LENW: begin
            elen_in  = LW'(len_rd_ff);
            i_in     = '0;
            mism_in  = 1'b0;
            state_in = S_RD;
         end
         S_RD: begin
            if (i_ff == n) begin
               if (elen_ff < qlen_ff) begin
                  cmp_in = C_LT;
               end else if (elen_ff == qlen_ff) begin
                  cmp_in = C_EQ;
               end else begin
                  cmp_in = C_GT;
               end
               state_in = S_RESOLVE;
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (byte_rd_ff != tgt_rd_ff) begin
               cmp_in   = (byte_rd_ff < tgt_rd_ff) ? C_LT : C_GT;
               mism_in  = 1'b1;
               state_in = S_RESOLVE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_RESOLVE: begin
            if (!final_ff) begin
               if (cmp_ff == C_LT) begin
                  lo_in = CW'(entry_ff) + 1'b1;
               end else begin
                  hi_in = CW'(entry_ff);
               end
               state_in = S_STEP;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (cmp_ff == C_EQ) begin
                  rsp_in = '{status: ST_FOUND, match_index: 12'(entry_ff)};
               end else if (!mism_ff && elen_ff > qlen_ff) begin
                  rsp_in = '{status: ST_PREFIX, match_index: 12'(entry_ff)};
               end else begin
                  rsp_in = '{status: ST_NOTFOUND, match_index: '0};
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      count_ff <= count_in;
      qlen_ff  <= qlen_in;
      elen_ff  <= elen_in;
      i_ff     <= i_in;
      entry_ff <= entry_in;
      final_ff <= final_in;
      mism_ff  <= mism_in;
      cmp_ff   <= cmp_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign active    = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
endmodule

/* sv/swpl_checker.sv */
// Port-level checks of the lookup, bound to the top level.
`include "sorted_word_prefix_lookup_top_defines.svh"
module swpl_checker import swpl_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_word_type req_word,
   input logic         rsp_valid,
   input rsp_word_type rsp_word
);
   `SWPL_ASSERT_NEXT(query_end_busy, start && !busy && req_word.command == CMD_QUERY && req_word.last, busy, "query end did not raise busy")
   `SWPL_ASSERT_NEXT(single_strobe, rsp_valid, !rsp_valid, "result strobes back to back")
   `SWPL_ASSERT_IMPL(miss_zero_index, rsp_valid && (rsp_word.status == ST_NOTFOUND || rsp_word.status == ST_TOOLONG), rsp_word.match_index == 12'd0, "miss with nonzero index")
   `SWPL_ASSERT_RESET(reset_quiet, !rsp_valid && !busy, "activity right after reset")
endmodule

bind sorted_word_prefix_lookup_top swpl_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);
